// ===== src/chord_expander_with_inversion_top_assert.svh =====
// Assertion macros for the chord expander.
// Included by the top level; depends on nothing else.
`ifndef CHORD_EXPANDER_WITH_INVERSION_TOP_ASSERT_SVH
`define CHORD_EXPANDER_WITH_INVERSION_TOP_ASSERT_SVH

// Condition in a cycle implies a consequence in the same cycle.
`define CEWI_ASSERT_IMPLIES(name, clk, rst_n, cond, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |-> (cons)) \
        else $error("assertion failed: cond implies cons");

// Condition in a cycle implies a consequence in the following cycle.
`define CEWI_ASSERT_NEXT(name, clk, rst_n, cond, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (cons)) \
        else $error("assertion failed: cond implies cons one cycle later");

`endif

// ===== src/cewi_pkg.sv =====
// Shared types, constants and the voicing table of the chord expander.
// Depends on nothing; used by every module of the block.
`default_nettype none

package cewi_pkg;

    localparam int TONES_MAX  = 5;
    localparam int NUM_VOICES = 16;
    localparam int CFG_DATA_W = 4;
    localparam int CFG_INDEX_W = 2;

    typedef logic [6:0] note_t;
    typedef logic [2:0] tone_cnt_t;
    typedef logic [$clog2(TONES_MAX)-1:0] tone_idx_t;
    typedef logic [3:0] voice_sel_t;
    typedef logic [1:0] inv_cnt_t;

    localparam note_t NOTE_MAX = 7'd127;
    localparam note_t OCTAVE   = 7'd12;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_CHORD_ENABLE    = 2'd0,
        CFG_CHORD_SELECT    = 2'd1,
        CFG_INVERSION_COUNT = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic       chord_enable;
        voice_sel_t chord_select;
        inv_cnt_t   inversion_count;
    } cfg_t;

    typedef struct packed {
        note_t root_note;
        note_t note_velocity;
    } in_item_t;

    typedef struct packed {
        note_t out_note;
        note_t out_velocity;
        logic  last_note;
    } out_item_t;

    typedef struct packed {
        note_t [TONES_MAX-1:0] tones;
        tone_cnt_t             count;
        note_t                 velocity;
    } job_t;

    localparam note_t VOICING_STEPS [NUM_VOICES][TONES_MAX] = '{
        '{7'd0, 7'd4,  7'd7, 7'd0,  7'd0},
        '{7'd0, 7'd3,  7'd7, 7'd0,  7'd0},
        '{7'd0, 7'd4,  7'd7, 7'd10, 7'd0},
        '{7'd0, 7'd4,  7'd7, 7'd11, 7'd0},
        '{7'd0, 7'd3,  7'd7, 7'd10, 7'd0},
        '{7'd0, 7'd2,  7'd7, 7'd0,  7'd0},
        '{7'd0, 7'd5,  7'd7, 7'd0,  7'd0},
        '{7'd0, 7'd3,  7'd6, 7'd0,  7'd0},
        '{7'd0, 7'd3,  7'd6, 7'd9,  7'd0},
        '{7'd0, 7'd4,  7'd8, 7'd0,  7'd0},
        '{7'd0, 7'd3,  7'd6, 7'd10, 7'd0},
        '{7'd0, 7'd4,  7'd7, 7'd14, 7'd0},
        '{7'd0, 7'd4,  7'd7, 7'd11, 7'd14},
        '{7'd0, 7'd3,  7'd7, 7'd10, 7'd14},
        '{7'd0, 7'd7,  7'd0, 7'd0,  7'd0},
        '{7'd0, 7'd12, 7'd0, 7'd0,  7'd0}
    };

    localparam tone_cnt_t VOICING_SIZE [NUM_VOICES] = '{
        3'd3, 3'd3, 3'd4, 3'd4, 3'd4, 3'd3, 3'd3, 3'd3,
        3'd4, 3'd3, 3'd4, 3'd4, 3'd5, 3'd5, 3'd2, 3'd2
    };

    function automatic note_t clamp_add(input note_t a, input note_t b);
        logic [7:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return (sum > {1'b0, NOTE_MAX}) ? NOTE_MAX : sum[6:0];
    endfunction

endpackage

`default_nettype wire

// ===== src/cewi_front.sv =====
// Front end: accepts a transaction, builds the clamped chord and applies
// the inversions one per cycle. Depends on cewi_pkg.
`default_nettype none

module cewi_front (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire cewi_pkg::cfg_t     cfg,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire cewi_pkg::in_item_t s_data,
    output logic                    q_valid,
    output cewi_pkg::job_t          q_data,
    input  wire logic               q_ready
);

    logic               busy_reg, busy_next;
    cewi_pkg::inv_cnt_t inv_left_reg, inv_left_next;
    cewi_pkg::job_t     job_reg, job_next;
    cewi_pkg::job_t     load_job, inv_job;
    cewi_pkg::inv_cnt_t load_inv;
    cewi_pkg::tone_idx_t low;
    logic               accept;

    always_comb begin
        load_job          = '0;
        load_job.velocity = s_data.note_velocity;
        if (cfg.chord_enable) begin
            load_job.count = cewi_pkg::VOICING_SIZE[cfg.chord_select];
            for (int i = 0; i < cewi_pkg::TONES_MAX; i++) begin
                if (cewi_pkg::tone_cnt_t'(i) < load_job.count) begin
                    load_job.tones[i] = cewi_pkg::clamp_add(s_data.root_note,
                        cewi_pkg::VOICING_STEPS[cfg.chord_select][i]);
                end
            end
            load_inv = cfg.inversion_count;
        end else begin
            load_job.count    = 3'd1;
            load_job.tones[0] = s_data.root_note;
            load_inv          = '0;
        end
    end

    always_comb begin
        low = '0;
        for (int i = 1; i < cewi_pkg::TONES_MAX; i++) begin
            if (cewi_pkg::tone_cnt_t'(i) < job_reg.count &&
                job_reg.tones[i] < job_reg.tones[low]) begin
                low = cewi_pkg::tone_idx_t'(i);
            end
        end
        inv_job            = job_reg;
        inv_job.tones[low] = cewi_pkg::clamp_add(job_reg.tones[low], cewi_pkg::OCTAVE);
    end

    assign q_valid = busy_reg && (inv_left_reg == '0);
    assign q_data  = job_reg;
    assign s_ready = !busy_reg || ((inv_left_reg == '0) && q_ready);
    assign accept  = s_valid && s_ready;

    always_comb begin
        busy_next     = busy_reg;
        inv_left_next = inv_left_reg;
        job_next      = job_reg;
        if (busy_reg && inv_left_reg != '0) begin
            job_next      = inv_job;
            inv_left_next = inv_left_reg - 2'd1;
        end else if (q_valid && q_ready) begin
            busy_next = 1'b0;
        end
        if (accept) begin
            busy_next     = 1'b1;
            job_next      = load_job;
            inv_left_next = load_inv;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg     <= 1'b0;
            inv_left_reg <= '0;
        end else begin
            busy_reg     <= busy_next;
            inv_left_reg <= inv_left_next;
        end
        job_reg <= job_next;
    end

endmodule

`default_nettype wire

// ===== src/cewi_queue.sv =====
// Short queue of prepared chords between the front and back ends.
// Depends on cewi_pkg.
`default_nettype none

module cewi_queue #(
    parameter int DEPTH = 2
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire cewi_pkg::job_t in_data,
    output logic                out_valid,
    input  wire logic           out_ready,
    output cewi_pkg::job_t      out_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cewi_pkg::job_t   mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    assign in_ready  = count_reg != CNT_W'(DEPTH);
    assign out_valid = count_reg != '0;
    assign out_data  = mem_reg[rd_ptr_reg];
    assign do_wr     = in_valid && in_ready;
    assign do_rd     = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd) begin
            count_next = count_reg + 1'b1;
        end else if (do_rd && !do_wr) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (do_wr) begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

`default_nettype wire

// ===== src/cewi_back.sv =====
// Back end: takes queued chords and, while m_ready allows, sends their
// notes one per cycle via a registered output. Depends on cewi_pkg.
`default_nettype none

module cewi_back (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           q_valid,
    output logic                q_ready,
    input  wire cewi_pkg::job_t q_data,
    output logic                m_valid,
    input  wire logic           m_ready,
    output cewi_pkg::out_item_t m_data
);

    logic                have_job_reg, have_job_next;
    cewi_pkg::job_t      job_reg, job_next;
    cewi_pkg::tone_idx_t idx_reg, idx_next;
    logic                m_valid_reg, m_valid_next;
    cewi_pkg::out_item_t m_data_reg, m_data_next;
    logic                adv, is_last, load;

    assign adv     = have_job_reg && (!m_valid_reg || m_ready);
    assign is_last = {1'b0, idx_reg} == {1'b0, job_reg.count - 3'd1};
    assign load    = !have_job_reg || (adv && is_last);
    assign q_ready = load;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        have_job_next = have_job_reg;
        job_next      = job_reg;
        idx_next      = idx_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_data_next   = m_data_reg;
        if (adv) begin
            m_valid_next             = 1'b1;
            m_data_next.out_note     = job_reg.tones[idx_reg];
            m_data_next.out_velocity = job_reg.velocity;
            m_data_next.last_note    = is_last;
            if (!is_last) begin
                idx_next = idx_reg + 1'b1;
            end
        end
        if (load) begin
            have_job_next = q_valid;
            job_next      = q_data;
            idx_next      = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_job_reg <= 1'b0;
            idx_reg      <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            have_job_reg <= have_job_next;
            idx_reg      <= idx_next;
            m_valid_reg  <= m_valid_next;
        end
        job_reg    <= job_next;
        m_data_reg <= m_data_next;
    end

endmodule

`default_nettype wire

// ===== src/chord_expander_with_inversion_top.sv =====
// Top level of the chord expander: configuration registers, front end,
// chord queue and back end. Depends on cewi_pkg and the assertion header.
//
// Each input transaction on s_* carries a root note and a velocity. With
// chord expansion disabled one output transaction returns the root; when
// enabled the selected voicing yields two to five notes, all with the
// input velocity, the final one flagged by last_note.
// Configuration is written through cfg_wr_* with no wait; the user must
// write it only while idle, which the block itself does not enforce.
// The first note of a chord passes the front end's job register, where
// inversions are applied one per cycle, then the queue, the back end's
// job register and the output register. Chords flow at the pace of the
// slower of the inversion loop and the back end's one-note-per-cycle output.
// The queue lets the front end prepare the next chord while notes of
// the previous one are still being sent.
// When the receiver holds m_ready low the current note stays registered,
// the queue fills and s_ready then falls. Reset clears the registers to
// zero (expansion off) and empties the queue and the output.
`default_nettype none

`include "chord_expander_with_inversion_top_assert.svh"

module chord_expander_with_inversion_top #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  cfg_wr_en,
    input  wire logic [cewi_pkg::CFG_INDEX_W-1:0]      cfg_wr_index,
    input  wire logic [cewi_pkg::CFG_DATA_W-1:0]       cfg_wr_data,
    input  wire logic                                  s_valid,
    output logic                                       s_ready,
    input  wire cewi_pkg::in_item_t                    s_data,
    output logic                                       m_valid,
    input  wire logic                                  m_ready,
    output cewi_pkg::out_item_t                        m_data
);

    cewi_pkg::cfg_t cfg_reg;
    logic           fq_valid, fq_ready, qb_valid, qb_ready;
    cewi_pkg::job_t fq_data, qb_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                cewi_pkg::CFG_CHORD_ENABLE: begin
                    cfg_reg.chord_enable <= cfg_wr_data[0];
                end
                cewi_pkg::CFG_CHORD_SELECT: begin
                    cfg_reg.chord_select <= cfg_wr_data[3:0];
                end
                cewi_pkg::CFG_INVERSION_COUNT: begin
                    cfg_reg.inversion_count <= cfg_wr_data[1:0];
                end
                default: begin
                end
            endcase
        end
    end

    cewi_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_valid (fq_valid),
        .q_data  (fq_data),
        .q_ready (fq_ready)
    );

    cewi_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_data   (fq_data),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_data  (qb_data)
    );

    cewi_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (qb_valid),
        .q_ready (qb_ready),
        .q_data  (qb_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // A note that is not the last of its chord is always followed by another.
    `CEWI_ASSERT_NEXT(a_chord_continues, aclk, aresetn, m_valid && !m_data.last_note, m_valid)
    // A finished chord that the queue cannot take blocks new input.
    `CEWI_ASSERT_IMPLIES(a_front_blocks, aclk, aresetn, fq_valid && !fq_ready, !s_ready)

endmodule

`default_nettype wire
